@@ sv/lcg_icdf_pkg.sv @@
// ----------------------------------------------------------------------------
// lcg_icdf_pkg
// Shared constants for the sampler: generator coefficients, mode, error and
// register codes, and stream field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lcg_icdf_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam int MODE_W   = 2;
    localparam int ERR_W    = 2;
    localparam int INDEX_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 31;
    localparam int USED_W   = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 32;
    localparam int LCG_MUL_W  = 17;

    localparam logic [LCG_MUL_W-1:0] LCG_MUL = 17'd69069;
    localparam logic [31:0]          LCG_INC = 32'd1;

    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TABLE   = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOTAL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED         = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 8'd3;

endpackage

`default_nettype wire

@@ sv/lcg_inverse_cdf_sampler.sv @@
// ----------------------------------------------------------------------------
// lcg_inverse_cdf_sampler
// Random sample engine: a 69069 linear congruential generator feeding either
// a uniform range or a discrete inverse-CDF lookup over a loaded table.
// ----------------------------------------------------------------------------
// Load beats do not stall the input, which is ready again on the next cycle.
// A uniform sample runs one generator step, 32 steps of the shared restoring divider
// and a result state that waits on a stalled output; an empty range skips the divider.
// A table sample runs a total read, 32 divider steps, then one table RAM read per cycle
// until a hit or the last entry; a zero total skips the divider and goes to the result.
// Reset clears control state, seed and range, sets used to 1; table stays undefined.
`default_nettype none

module lcg_inverse_cdf_sampler #(
    parameter int TABLE_DEPTH = lcg_icdf_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // s_tdata: entry_index[5:0], entry_value[37:6], entry_weight[68:38], zero pad
    input  wire logic [lcg_icdf_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: mode[1:0]
    input  wire logic [lcg_icdf_pkg::MODE_W-1:0]      s_tuser,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // m_tdata: sample[31:0]
    output logic      [lcg_icdf_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: error[1:0]
    output logic      [lcg_icdf_pkg::ERR_W-1:0]       m_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lcg_icdf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lcg_icdf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int LW     = (IDX_W + 1 > lcg_icdf_pkg::USED_W) ? IDX_W + 1
                                                               : lcg_icdf_pkg::USED_W;
    localparam int RAM_W  = lcg_icdf_pkg::VALUE_W + lcg_icdf_pkg::WEIGHT_W;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W  = $clog2(DIV_STEPS);
    localparam int PROD_W = 32 + lcg_icdf_pkg::LCG_MUL_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADV   = 3'd1;
    localparam logic [2:0] ST_TWAIT = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SRCH  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [31:0] gen_reg, gen_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] end_reg, end_next;
    logic [lcg_icdf_pkg::USED_W-1:0] used_reg, used_next;
    logic        table_reg, table_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvd_reg, dvd_next;
    logic [31:0] div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [lcg_icdf_pkg::ERR_W-1:0] err_reg, err_next;
    logic [IDX_W-1:0] saddr_reg, saddr_next;
    logic [IDX_W-1:0] cidx_reg, cidx_next;
    logic        cvalid_reg, cvalid_next;
    logic [31:0] val_reg, val_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_sample_reg, out_sample_next;
    logic [lcg_icdf_pkg::ERR_W-1:0] out_err_reg, out_err_next;

    logic        in_beat;
    logic        cfg_beat;
    logic [PROD_W-1:0] prod;
    logic [31:0] gen_adv;
    logic [31:0] width;
    logic [LW-1:0] used_ext;
    logic [LW-1:0] last_w;
    logic [IDX_W-1:0] last_idx;
    logic [LW-1:0] widx_ext;
    logic        ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;
    logic [31:0] rd_value;
    logic [31:0] rd_weight;
    logic [32:0] trial;
    logic [32:0] trial_diff;
    logic [31:0] res_sample;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = s_tvalid && s_tready;
    assign cfg_beat  = cfg_valid && cfg_ready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_err_reg;

    assign prod    = PROD_W'(gen_reg) * PROD_W'(lcg_icdf_pkg::LCG_MUL);
    assign gen_adv = prod[31:0] + lcg_icdf_pkg::LCG_INC;
    assign width   = end_reg - start_reg;

    assign used_ext = LW'(used_reg);
    always_comb
    begin
        priority if (used_ext == '0)
        begin
            last_w = '0;
        end
        else if (used_ext > LW'(TABLE_DEPTH))
        begin
            last_w = LW'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_w = used_ext - LW'(1);
        end
    end
    assign last_idx = last_w[IDX_W-1:0];

    assign widx_ext  = LW'(s_tdata[lcg_icdf_pkg::INDEX_W-1:0]);
    assign ram_waddr = widx_ext[IDX_W-1:0];
    assign ram_we    = in_beat && (s_tuser == lcg_icdf_pkg::MODE_LOAD)
                       && (widx_ext < LW'(TABLE_DEPTH));
    assign ram_wdata = s_tdata[68:6];
    assign ram_raddr = (state_reg == ST_SRCH) ? saddr_reg : last_idx;

    assign rd_value  = ram_rdata[31:0];
    assign rd_weight = {1'b0, ram_rdata[RAM_W-1:32]};

    assign trial      = {rem_reg, dvd_reg[31]};
    assign trial_diff = trial - {1'b0, div_reg};

    assign res_sample = (err_reg != lcg_icdf_pkg::ERR_OK) ? 32'd0
                      : (table_reg ? val_reg : start_reg + rem_reg);

    lcg_icdf_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        gen_next        = gen_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        used_next       = used_reg;
        table_next      = table_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        div_next        = div_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        saddr_next      = saddr_reg;
        cidx_next       = cidx_reg;
        cvalid_next     = cvalid_reg;
        val_next        = val_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        out_err_next    = out_err_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_beat)
        begin
            unique case (cfg_index)
                lcg_icdf_pkg::CFG_SEED:         gen_next   = cfg_data;
                lcg_icdf_pkg::CFG_RANGE_START:  start_next = cfg_data;
                lcg_icdf_pkg::CFG_RANGE_END:    end_next   = cfg_data;
                lcg_icdf_pkg::CFG_ENTRIES_USED: used_next  = cfg_data[lcg_icdf_pkg::USED_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat && (s_tuser == lcg_icdf_pkg::MODE_UNIFORM
                                || s_tuser == lcg_icdf_pkg::MODE_TABLE))
                begin
                    table_next = (s_tuser == lcg_icdf_pkg::MODE_TABLE);
                    err_next   = lcg_icdf_pkg::ERR_OK;
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                gen_next = gen_adv;
                dvd_next = gen_adv;
                rem_next = '0;
                cnt_next = '0;
                if (table_reg)
                begin
                    state_next = ST_TWAIT;
                end
                else if (width == 32'd0)
                begin
                    err_next   = lcg_icdf_pkg::ERR_RANGE;
                    state_next = ST_FIN;
                end
                else
                begin
                    div_next   = width;
                    state_next = ST_DIV;
                end
            end
            ST_TWAIT:
            begin
                if (rd_weight == 32'd0)
                begin
                    err_next   = lcg_icdf_pkg::ERR_TOTAL;
                    state_next = ST_FIN;
                end
                else
                begin
                    div_next   = rd_weight;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!trial_diff[32])
                begin
                    rem_next = trial_diff[31:0];
                end
                else
                begin
                    rem_next = trial[31:0];
                end
                dvd_next = {dvd_reg[30:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    saddr_next  = '0;
                    cidx_next   = '0;
                    cvalid_next = 1'b0;
                    state_next  = table_reg ? ST_SRCH : ST_FIN;
                end
            end
            ST_SRCH:
            begin
                cvalid_next = 1'b1;
                if (saddr_reg != last_idx)
                begin
                    saddr_next = saddr_reg + IDX_W'(1);
                end
                if (cvalid_reg)
                begin
                    if ((rd_weight > rem_reg) || (cidx_reg == last_idx))
                    begin
                        val_next   = rd_value;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cidx_next = cidx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = res_sample;
                    out_err_next    = err_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            used_reg      <= lcg_icdf_pkg::USED_W'(1);
            out_valid_reg <= 1'b0;
            cvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            cvalid_reg    <= cvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        table_reg      <= table_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        div_reg        <= div_next;
        cnt_reg        <= cnt_next;
        err_reg        <= err_next;
        saddr_reg      <= saddr_next;
        cidx_reg       <= cidx_next;
        val_reg        <= val_next;
        out_sample_reg <= out_sample_next;
        out_err_reg    <= out_err_next;
    end

endmodule

`default_nettype wire

@@ sv/lcg_icdf_ram.sv @@
// ----------------------------------------------------------------------------
// lcg_icdf_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_icdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ sv/lcg_icdf_checker.sv @@
// ----------------------------------------------------------------------------
// lcg_icdf_checker
// Port-level checks for the sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_icdf_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic [lcg_icdf_pkg::MODE_W-1:0]      s_tuser,
    input wire logic                                 s_tvalid,
    input wire logic                                 s_tready,
    input wire logic [lcg_icdf_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic [lcg_icdf_pkg::ERR_W-1:0]       m_tuser,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready
);

    // A sample request keeps the input stalled while it is worked on.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == lcg_icdf_pkg::MODE_UNIFORM
                                  || s_tuser == lcg_icdf_pkg::MODE_TABLE))
        |=> !s_tready)
        else $error("input ready straight after a sample request");

    // A load beat finishes in its own cycle.
    a_ready_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == lcg_icdf_pkg::MODE_LOAD) |=> s_tready)
        else $error("input not ready after a load beat");

    // A failed sample carries a zero value.
    a_error_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != lcg_icdf_pkg::ERR_OK) |-> (m_tdata == '0))
        else $error("error result with non-zero sample");

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result beat changed while stalled");

endmodule

bind lcg_inverse_cdf_sampler lcg_icdf_checker u_lcg_icdf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
